// ===== hdl/rrts_pkg.sv =====
// ---------------------------------------------------------------------------
// rrts_pkg - shared types and codes of the round-robin task scheduler
// Request modes, result status codes, slot state codes and the control
// state machine encoding.
// ---------------------------------------------------------------------------
package rrts_pkg;

    // request modes
    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_YIELD  = 2'd2;
    localparam logic [1:0] MODE_EXIT   = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    // slot state codes
    localparam logic [1:0] SLOT_EMPTY    = 2'd0;
    localparam logic [1:0] SLOT_READY    = 2'd1;
    localparam logic [1:0] SLOT_RUNNING  = 2'd2;
    localparam logic [1:0] SLOT_FINISHED = 2'd3;

    localparam int unsigned ID_W  = 32;
    localparam int unsigned CTX_W = 64;

    typedef enum logic [5:0] {
        FSM_IDLE  = 6'b000001,
        FSM_SCAN  = 6'b000010,
        FSM_MARK  = 6'b000100,
        FSM_SWAP  = 6'b001000,
        FSM_FETCH = 6'b010000,
        FSM_RESP  = 6'b100000
    } t_fsm;

endpackage

// ===== hdl/round_robin_task_scheduler_top.sv =====
// ---------------------------------------------------------------------------
// round_robin_task_scheduler_top - cooperative round-robin task table
// Creates tasks, starts the first one and passes control between them on
// yield and exit requests, one request at a time.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_ready with i_mode and the two context
//   words; each request gives exactly one result on o_out_valid / i_out_ready.
//   Create and every ignored or refused request go straight to the result
//   register; start passes through the swap and fetch states. Yield and exit
//   step through the slot state memory one slot a cycle, set by the single
//   read port of that memory. The next request is taken once the previous
//   one has reached the result register.
//   The slot table sits in two synchronous memories (slot state; id and
//   context) that are read, modified and written back by the sequencer.
//   Only slots below the fill count are ever read, so the memories need no
//   clearing; clearing the table just zeroes the fill count.
//   Reset (synchronous, active low) empties the table, drops the current
//   task, sets the id counter to one and zeroes the scheduler context.
//   When the receiver stalls, the result waits in the output register and
//   one more request may be accepted; it then holds until the output frees.
// ---------------------------------------------------------------------------
module round_robin_task_scheduler_top #(
    parameter int unsigned MAX_LIVE    = 16,
    parameter int unsigned TABLE_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_start_context,
    input  logic [63:0] i_saved_context,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_task_id,
    output logic        o_switched,
    output logic        o_to_scheduler,
    output logic [63:0] o_resume_context,
    output logic [4:0]  o_live_count
);

    localparam int unsigned SW = $clog2(TABLE_SLOTS);      // slot index width
    localparam int unsigned UW = $clog2(TABLE_SLOTS + 1);  // fill count width
    localparam int unsigned LW = $clog2(MAX_LIVE + 1);     // live count width
    localparam int unsigned DW = rrts_pkg::ID_W + rrts_pkg::CTX_W;

    // slot memories
    logic [1:0]    mem_st [TABLE_SLOTS];
    logic [DW-1:0] mem_dat[TABLE_SLOTS];
    logic [1:0]    r_st_rd;
    logic [DW-1:0] r_dat_rd;

    // control and table state
    rrts_pkg::t_fsm r_state, n_state;
    logic [UW-1:0]  r_used;
    logic [LW-1:0]  r_live;
    logic           r_cur_valid;
    logic [SW-1:0]  r_cur;
    logic [31:0]    r_cur_id;
    logic [31:0]    r_id_ctr;
    logic [63:0]    r_sched_ctx;

    // request held while it is worked on
    logic [1:0]     r_mode;
    logic [63:0]    r_saved;

    // scan and switch
    logic [SW-1:0]  r_scan_addr;
    logic [UW-1:0]  r_scan_left;
    logic           r_chk_valid;
    logic [SW-1:0]  r_chk_addr;
    logic [SW-1:0]  r_nx;

    // result waiting for the output register
    logic [1:0]     r_res_status;
    logic [31:0]    r_res_tid;
    logic           r_res_sw;
    logic           r_res_tosch;
    logic [63:0]    r_res_resume;

    logic           r_out_valid;
    logic [1:0]     r_out_status;
    logic [31:0]    r_out_tid;
    logic           r_out_sw;
    logic           r_out_tosch;
    logic [63:0]    r_out_resume;
    logic [4:0]     r_out_live;

    logic           in_acc;
    logic           table_full;
    logic           scan_hit;
    logic           out_free;
    logic           st_we;
    logic [SW-1:0]  st_waddr;
    logic [1:0]     st_wdata;
    logic           dat_we;
    logic [SW-1:0]  dat_waddr;
    logic [DW-1:0]  dat_wdata;

    // step circularly over the used slots
    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] a,
                                                input logic [UW-1:0] used);
        logic [UW:0] inc;
        begin
            inc = (UW+1)'(a) + (UW+1)'(1);
            next_slot = (inc == {1'b0, used}) ? '0 : SW'(inc);
        end
    endfunction

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == rrts_pkg::FSM_IDLE);
    assign table_full = (r_live >= LW'(MAX_LIVE)) || (r_used >= UW'(TABLE_SLOTS));
    assign scan_hit   = r_chk_valid && (r_st_rd == rrts_pkg::SLOT_READY);
    assign out_free   = !r_out_valid || i_out_ready;

    // memory write ports: one state write and one id/context write per cycle
    always_comb begin
        st_we     = 1'b0;
        st_waddr  = r_cur;
        st_wdata  = rrts_pkg::SLOT_EMPTY;
        dat_we    = 1'b0;
        dat_waddr = r_cur;
        dat_wdata = {r_cur_id, i_saved_context};
        case (r_state)
            rrts_pkg::FSM_IDLE: begin
                if (in_acc) begin
                    case (i_mode)
                        rrts_pkg::MODE_CREATE: begin
                            if (!table_full) begin
                                st_we     = 1'b1;
                                st_waddr  = r_used[SW-1:0];
                                st_wdata  = rrts_pkg::SLOT_READY;
                                dat_we    = 1'b1;
                                dat_waddr = r_used[SW-1:0];
                                dat_wdata = {r_id_ctr, i_start_context};
                            end
                        end
                        rrts_pkg::MODE_YIELD: begin
                            // save the outgoing context of the running task
                            dat_we = r_cur_valid;
                        end
                        rrts_pkg::MODE_EXIT: begin
                            st_we    = r_cur_valid;
                            st_wdata = rrts_pkg::SLOT_FINISHED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rrts_pkg::FSM_MARK: begin
                st_we    = 1'b1;
                st_wdata = rrts_pkg::SLOT_READY;
            end
            rrts_pkg::FSM_SWAP: begin
                st_we    = 1'b1;
                st_waddr = r_nx;
                st_wdata = rrts_pkg::SLOT_RUNNING;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            mem_st[st_waddr] <= st_wdata;
        end
        r_st_rd <= mem_st[r_scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (dat_we) begin
            mem_dat[dat_waddr] <= dat_wdata;
        end
        r_dat_rd <= mem_dat[r_nx];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            rrts_pkg::FSM_IDLE: begin
                if (in_acc) begin
                    case (i_mode)
                        rrts_pkg::MODE_START: begin
                            n_state = (r_used == '0 || r_cur_valid) ?
                                      rrts_pkg::FSM_RESP : rrts_pkg::FSM_SWAP;
                        end
                        rrts_pkg::MODE_YIELD, rrts_pkg::MODE_EXIT: begin
                            n_state = r_cur_valid ? rrts_pkg::FSM_SCAN
                                                  : rrts_pkg::FSM_RESP;
                        end
                        default: n_state = rrts_pkg::FSM_RESP;
                    endcase
                end
            end
            rrts_pkg::FSM_SCAN: begin
                if (scan_hit) begin
                    n_state = (r_mode == rrts_pkg::MODE_YIELD) ?
                              rrts_pkg::FSM_MARK : rrts_pkg::FSM_SWAP;
                end else if (r_scan_left == '0) begin
                    n_state = rrts_pkg::FSM_RESP;
                end
            end
            rrts_pkg::FSM_MARK:  n_state = rrts_pkg::FSM_SWAP;
            rrts_pkg::FSM_SWAP:  n_state = rrts_pkg::FSM_FETCH;
            rrts_pkg::FSM_FETCH: n_state = rrts_pkg::FSM_RESP;
            rrts_pkg::FSM_RESP: begin
                if (out_free) begin
                    n_state = rrts_pkg::FSM_IDLE;
                end
            end
            default: n_state = rrts_pkg::FSM_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrts_pkg::FSM_IDLE;
            r_used      <= '0;
            r_live      <= '0;
            r_cur_valid <= 1'b0;
            r_id_ctr    <= 32'd1;
            r_sched_ctx <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                rrts_pkg::FSM_IDLE: begin
                    r_chk_valid <= 1'b0;
                    if (in_acc) begin
                        case (i_mode)
                            rrts_pkg::MODE_CREATE: begin
                                if (!table_full) begin
                                    r_id_ctr <= r_id_ctr + 32'd1;
                                    r_used   <= r_used + UW'(1);
                                    r_live   <= r_live + LW'(1);
                                end
                            end
                            rrts_pkg::MODE_START: begin
                                if (r_used != '0 && !r_cur_valid) begin
                                    r_sched_ctx <= i_saved_context;
                                    r_cur_valid <= 1'b1;
                                end
                            end
                            rrts_pkg::MODE_EXIT: begin
                                if (r_cur_valid && r_live != '0) begin
                                    r_live <= r_live - LW'(1);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                rrts_pkg::FSM_SCAN: begin
                    if (!scan_hit && r_scan_left != '0) begin
                        r_chk_valid <= 1'b1;
                    end else if (!scan_hit && r_mode == rrts_pkg::MODE_EXIT) begin
                        // nothing left to run: drop the table
                        r_cur_valid <= 1'b0;
                        r_used      <= '0;
                        r_live      <= '0;
                    end
                end
                default: begin
                end
            endcase
            if (r_state == rrts_pkg::FSM_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            rrts_pkg::FSM_IDLE: begin
                if (in_acc) begin
                    r_mode       <= i_mode;
                    r_saved      <= i_saved_context;
                    r_scan_addr  <= next_slot(r_cur, r_used);
                    r_scan_left  <= r_used - UW'(1);
                    r_nx         <= '0;
                    r_res_status <= rrts_pkg::STATUS_DONE;
                    r_res_tid    <= '0;
                    r_res_sw     <= 1'b0;
                    r_res_tosch  <= 1'b0;
                    r_res_resume <= '0;
                    case (i_mode)
                        rrts_pkg::MODE_CREATE: begin
                            if (table_full) begin
                                r_res_status <= rrts_pkg::STATUS_FULL;
                            end else begin
                                r_res_tid <= r_id_ctr;
                            end
                        end
                        rrts_pkg::MODE_START: begin
                            if (r_used == '0 || r_cur_valid) begin
                                r_res_status <= rrts_pkg::STATUS_IGNORED;
                            end else begin
                                r_cur <= '0;
                            end
                        end
                        default: begin
                            if (!r_cur_valid) begin
                                r_res_status <= rrts_pkg::STATUS_IGNORED;
                            end
                        end
                    endcase
                end
            end
            rrts_pkg::FSM_SCAN: begin
                if (scan_hit) begin
                    r_nx <= r_chk_addr;
                end else if (r_scan_left != '0) begin
                    // issue the next slot read, check it in the following cycle
                    r_chk_addr  <= r_scan_addr;
                    r_scan_addr <= next_slot(r_scan_addr, r_used);
                    r_scan_left <= r_scan_left - UW'(1);
                end else if (r_mode == rrts_pkg::MODE_EXIT) begin
                    r_res_tosch  <= 1'b1;
                    r_res_resume <= r_sched_ctx;
                end else begin
                    // no other runnable task: keep the current one
                    r_res_tid    <= r_cur_id;
                    r_res_resume <= r_saved;
                end
            end
            rrts_pkg::FSM_FETCH: begin
                r_cur        <= r_nx;
                r_cur_id     <= r_dat_rd[DW-1 -: rrts_pkg::ID_W];
                r_res_tid    <= r_dat_rd[DW-1 -: rrts_pkg::ID_W];
                r_res_resume <= r_dat_rd[rrts_pkg::CTX_W-1:0];
                r_res_sw     <= 1'b1;
            end
            rrts_pkg::FSM_RESP: begin
                if (out_free) begin
                    r_out_status <= r_res_status;
                    r_out_tid    <= r_res_tid;
                    r_out_sw     <= r_res_sw;
                    r_out_tosch  <= r_res_tosch;
                    r_out_resume <= r_res_resume;
                    r_out_live   <= 5'(r_live);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_task_id        = r_out_tid;
    assign o_switched       = r_out_sw;
    assign o_to_scheduler   = r_out_tosch;
    assign o_resume_context = r_out_resume;
    assign o_live_count     = r_out_live;

    // a current task always lies inside the filled part of the table
    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_used != '0 && UW'(r_cur) < r_used))
        else $error("current slot outside the filled table");

    // unfinished tasks never outnumber the filled slots
    a_live_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (UW + LW)'(r_live) <= (UW + LW)'(r_used))
        else $error("live count exceeds fill count");

    // a return to the scheduler leaves no live task
    a_tosch_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_to_scheduler) |-> (o_live_count == '0 && !o_switched))
        else $error("return to scheduler with live tasks");

    // a scan only runs for a request that has a current task
    a_scan_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrts_pkg::FSM_SCAN) |-> $past(r_cur_valid))
        else $error("scan without a current task");

endmodule
